// ===== rtl/ptr_pkg.sv =====
// Shared constants, control word types and the microcode ROM for the
// pedal-to-torque request block. No dependencies.
`timescale 1ns / 1ps

package ptr_pkg;

   // Field widths and fixed-point constants
   localparam int PEDAL_BITS = 12;
   localparam int SPEED_BITS = 16;
   localparam int FULL_PCT = 25600;
   localparam int REGEN_MIN_RPM = 100;

   // Datapath widths: multiplier operands, signed numerator, magnitudes
   localparam int OPW = 18;
   localparam int NUMW = 33;
   localparam int MAGW = 32;
   localparam int DMAGW = 17;
   localparam int DIV_CNT_W = 4;
   localparam int TORQUE_W = 16;
   // Unsigned width for speed compares against 16-bit rpm band limits
   localparam int CMP_W = ((SPEED_BITS > 16) ? SPEED_BITS : 16) + 1;
   // Signed width for the slew difference against the 15-bit slew limit
   localparam int DIF_W = ((SPEED_BITS > 15) ? SPEED_BITS : 15) + 2;

   localparam logic signed [OPW-1:0] FULL_PCT_OP = OPW'(FULL_PCT);

   // Configuration register map
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int PRANGE_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_PEDAL0_RANGE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PEDAL1_RANGE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REGEN_SPEED_BAND = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REGEN_PEDAL_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REGEN_BRAKE_LEVEL = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_CEILING = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_ZONE = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_RPM_SLEW = 3'd7;
   localparam logic [14:0] THROTTLE_CEILING_RST = 15'd25600;
   localparam logic [14:0] RPM_SLEW_RST = 15'd100;

   // Microcode step addresses
   localparam int UPC_W = 5;
   localparam logic [UPC_W-1:0] U_IDLE = 5'd0;
   localparam logic [UPC_W-1:0] U_SLEW = 5'd1;
   localparam logic [UPC_W-1:0] U_BRK = 5'd2;
   localparam logic [UPC_W-1:0] U_PED_MUL = 5'd3;
   localparam logic [UPC_W-1:0] U_PED_DIV = 5'd4;
   localparam logic [UPC_W-1:0] U_PED_WAIT = 5'd5;
   localparam logic [UPC_W-1:0] U_PED_WB = 5'd6;
   localparam logic [UPC_W-1:0] U_DZ_MUL = 5'd7;
   localparam logic [UPC_W-1:0] U_DZ_DIV = 5'd8;
   localparam logic [UPC_W-1:0] U_DZ_WAIT = 5'd9;
   localparam logic [UPC_W-1:0] U_DZ_WB = 5'd10;
   localparam logic [UPC_W-1:0] U_DIR = 5'd11;
   localparam logic [UPC_W-1:0] U_FT_CHK = 5'd12;
   localparam logic [UPC_W-1:0] U_FT_DIV = 5'd13;
   localparam logic [UPC_W-1:0] U_FT_WAIT = 5'd14;
   localparam logic [UPC_W-1:0] U_FT_WB = 5'd15;
   localparam logic [UPC_W-1:0] U_FWD_MUL = 5'd16;
   localparam logic [UPC_W-1:0] U_FWD_DIV = 5'd17;
   localparam logic [UPC_W-1:0] U_FWD_WAIT = 5'd18;
   localparam logic [UPC_W-1:0] U_FWD_WB = 5'd19;
   localparam logic [UPC_W-1:0] U_ZERO = 5'd20;
   localparam logic [UPC_W-1:0] U_BT_CHK = 5'd21;
   localparam logic [UPC_W-1:0] U_BT_DIV = 5'd22;
   localparam logic [UPC_W-1:0] U_BT_WAIT = 5'd23;
   localparam logic [UPC_W-1:0] U_BT_WB = 5'd24;
   localparam logic [UPC_W-1:0] U_BRK_RES = 5'd25;
   localparam logic [UPC_W-1:0] U_OUT = 5'd26;

   // Control word fields
   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_TAPER,    // (speed - regen end) * level
      MUL_PEDAL,    // FULL_PCT * (sample - min)
      MUL_DZ,       // (pedal - dead zone) * FULL_PCT
      MUL_FWD       // pedal * (ceiling - regen limit)
   } mul_op_type;

   typedef enum logic [2:0] {
      DIV_NONE,
      DIV_TAPER,    // full regen rpm - regen end rpm
      DIV_PEDAL,    // max - min
      DIV_DZ,       // FULL_PCT - dead zone
      DIV_PCT       // FULL_PCT
   } div_op_type;

   typedef enum logic {
      LVL_PEDAL,
      LVL_BRAKE
   } lvl_type;

   typedef enum logic [3:0] {
      WB_NONE,
      WB_SLEW,
      WB_LIM_EDGE,
      WB_LIM_Q,
      WB_PN_ZERO,
      WB_PN_CLAMP,
      WB_PN_Q,
      WB_RES_ZERO,
      WB_RES_LIM,
      WB_RES_PN,
      WB_RES_FWD,
      WB_EMIT
   } wb_op_type;

   typedef enum logic [3:0] {
      J_NEVER,
      J_ALWAYS,
      J_NO_ITEM,
      J_NEUTRAL,
      J_BRAKE,
      J_OUT_BAND,
      J_PEDAL_FLAT,
      J_DZ_ZERO,
      J_NOT_FWD,
      J_DIV_BUSY,
      J_OUT_BUSY
   } jmp_type;

   typedef struct packed {
      mul_op_type       mul;
      div_op_type       div;
      lvl_type          lvl;
      wb_op_type        wb;
      jmp_type          jmp;
      logic             ret;     // return to idle when the jump is not taken
      logic [UPC_W-1:0] target;
   } ctrl_type;

   localparam ctrl_type CW_NOP = '{
      mul: MUL_NONE, div: DIV_NONE, lvl: LVL_PEDAL, wb: WB_NONE,
      jmp: J_NEVER, ret: 1'b0, target: U_IDLE
   };

   // Microcode ROM: one control word per step
   function automatic ctrl_type ucode(input logic [UPC_W-1:0] addr);
      ctrl_type cw;
      cw = CW_NOP;
      case (addr)
         U_IDLE: begin
            cw.jmp = J_NO_ITEM; cw.target = U_IDLE;
         end
         U_SLEW: begin
            cw.wb = WB_SLEW; cw.jmp = J_NEUTRAL; cw.target = U_ZERO;
         end
         U_BRK: begin
            cw.jmp = J_BRAKE; cw.target = U_BT_CHK;
         end
         U_PED_MUL: begin
            cw.mul = MUL_PEDAL; cw.wb = WB_PN_ZERO;
            cw.jmp = J_PEDAL_FLAT; cw.target = U_DZ_MUL;
         end
         U_PED_DIV: cw.div = DIV_PEDAL;
         U_PED_WAIT: begin
            cw.jmp = J_DIV_BUSY; cw.target = U_PED_WAIT;
         end
         U_PED_WB: cw.wb = WB_PN_CLAMP;
         U_DZ_MUL: begin
            cw.mul = MUL_DZ; cw.wb = WB_PN_ZERO;
            cw.jmp = J_DZ_ZERO; cw.target = U_DIR;
         end
         U_DZ_DIV: cw.div = DIV_DZ;
         U_DZ_WAIT: begin
            cw.jmp = J_DIV_BUSY; cw.target = U_DZ_WAIT;
         end
         U_DZ_WB: cw.wb = WB_PN_Q;
         U_DIR: begin
            cw.wb = WB_RES_PN; cw.jmp = J_NOT_FWD; cw.target = U_OUT;
         end
         U_FT_CHK: begin
            cw.mul = MUL_TAPER; cw.lvl = LVL_PEDAL; cw.wb = WB_LIM_EDGE;
            cw.jmp = J_OUT_BAND; cw.target = U_FWD_MUL;
         end
         U_FT_DIV: cw.div = DIV_TAPER;
         U_FT_WAIT: begin
            cw.jmp = J_DIV_BUSY; cw.target = U_FT_WAIT;
         end
         U_FT_WB: cw.wb = WB_LIM_Q;
         U_FWD_MUL: cw.mul = MUL_FWD;
         U_FWD_DIV: cw.div = DIV_PCT;
         U_FWD_WAIT: begin
            cw.jmp = J_DIV_BUSY; cw.target = U_FWD_WAIT;
         end
         U_FWD_WB: begin
            cw.wb = WB_RES_FWD; cw.jmp = J_ALWAYS; cw.target = U_OUT;
         end
         U_ZERO: begin
            cw.wb = WB_RES_ZERO; cw.jmp = J_ALWAYS; cw.target = U_OUT;
         end
         U_BT_CHK: begin
            cw.mul = MUL_TAPER; cw.lvl = LVL_BRAKE; cw.wb = WB_LIM_EDGE;
            cw.jmp = J_OUT_BAND; cw.target = U_BRK_RES;
         end
         U_BT_DIV: cw.div = DIV_TAPER;
         U_BT_WAIT: begin
            cw.jmp = J_DIV_BUSY; cw.target = U_BT_WAIT;
         end
         U_BT_WB: cw.wb = WB_LIM_Q;
         U_BRK_RES: cw.wb = WB_RES_LIM;
         U_OUT: begin
            cw.wb = WB_EMIT; cw.jmp = J_OUT_BUSY; cw.target = U_OUT; cw.ret = 1'b1;
         end
         default: begin
            cw.jmp = J_ALWAYS; cw.target = U_IDLE;
         end
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/pedal_to_torque_request_top.sv =====
// Pedal-to-torque request block: microcoded sequencer, shared multiplier
// and shared radix-4 divider. Depends on ptr_pkg.
`timescale 1ns / 1ps

// Each accepted item yields exactly one torque request. The item runs
// through a short microprogram that drives one 18x18 multiplier and one
// divider producing two quotient bits per cycle. The path of an item
// holds no division in neutral, up to one when braking, up to two in
// reverse and up to four in forward with the pedal pressed. One item is
// in work at a time; the next is accepted as soon as the result has moved
// into the output register, even while that result still waits under
// rsp_stall. Configuration writes are always taken.
module pedal_to_torque_request_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [ptr_pkg::PEDAL_BITS-1:0]          req_pedal_sample,
   input  logic                                    req_pedal_channel,
   input  logic                                    req_brake_pressed,
   input  logic signed [ptr_pkg::SPEED_BITS-1:0]   req_motor_speed,
   input  logic signed [1:0]                       req_drive_direction,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [ptr_pkg::TORQUE_W-1:0]     rsp_torque_request,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ptr_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [ptr_pkg::CSR_DATA_W-1:0]          csr_data
);

   localparam int PB = ptr_pkg::PEDAL_BITS;
   localparam int SB = ptr_pkg::SPEED_BITS;
   localparam int OPW = ptr_pkg::OPW;
   localparam int NUMW = ptr_pkg::NUMW;
   localparam int MAGW = ptr_pkg::MAGW;
   localparam int DMAGW = ptr_pkg::DMAGW;
   localparam int CMPW = ptr_pkg::CMP_W;
   localparam int DIFW = ptr_pkg::DIF_W;

   // Configuration registers
   logic [ptr_pkg::PRANGE_W-1:0] pedal0_range_ff, pedal1_range_ff;
   logic [31:0]                  regen_speed_band_ff;
   logic signed [15:0]           regen_pedal_limit_ff, regen_brake_level_ff;
   logic [14:0]                  throttle_ceiling_ff, dead_zone_ff, rpm_slew_ff;

   // Latched item, sequencer and datapath registers
   logic [PB-1:0]            pv_ff;
   logic                     chan_ff, brake_ff;
   logic signed [SB-1:0]     speed_ff;
   logic signed [1:0]        dir_ff;
   logic [ptr_pkg::UPC_W-1:0] upc_ff, upc_in;
   logic [SB-1:0]            spd_ff, spd_in;
   logic signed [NUMW-1:0]   prod_ff;
   logic [15:0]              pn_ff, pn_in;
   logic signed [16:0]       lim_ff, lim_in;
   logic signed [17:0]       res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [ptr_pkg::TORQUE_W-1:0] rsp_data_ff;

   // Divider registers
   logic                     div_busy_ff, div_neg_ff;
   logic [ptr_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [17:0]              div_rem_ff, div_rem_in;
   logic [MAGW-1:0]          div_quo_ff, div_quo_in;
   logic [DMAGW-1:0]         div_dmag_ff;

   ptr_pkg::ctrl_type cw;
   logic              accept, taken, out_busy, emit;

   // Operand views
   logic [2*PB+ptr_pkg::PRANGE_W-1:0] prange;
   logic [PB-1:0]          pmin, pmax;
   logic signed [PB:0]     pdiff_v, pspan_v;
   logic [CMPW-1:0]        spd_c, band_end_c, band_full_c, min_rpm_c;
   logic [CMPW-1:0]        spd_end_c, full_end_c;
   logic                   below_band, out_band, dz_zero, pedal_flat;
   logic signed [15:0]     level;
   logic signed [OPW-1:0]  mul_a, mul_b, div_den;
   logic signed [2*OPW-1:0] mul_p;
   logic signed [NUMW-1:0] div_q;
   logic [DMAGW-1:0]       den_mag;
   logic [MAGW-1:0]        num_mag;
   logic signed [NUMW-1:0] prod_neg;
   logic signed [OPW-1:0]  den_neg;

   // Slew and divider step temporaries
   logic [SB-1:0]          spd_abs;
   logic signed [SB:0]     speed_neg;
   logic signed [DIFW-1:0] sl_diff, sl_slew;
   logic [17:0]            dv_sh;
   logic [18:0]            dv_t;
   logic [17:0]            dv_r;
   logic [MAGW-1:0]        dv_q;

   assign cw = ptr_pkg::ucode(upc_ff);
   assign req_stall = (upc_ff != ptr_pkg::U_IDLE);
   assign accept = req_valid && !req_stall;
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign emit = (cw.wb == ptr_pkg::WB_EMIT) && !out_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_torque_request = rsp_data_ff;
   assign csr_ready = 1'b1;

   // Operand selection from configuration and state
   always_comb begin
      prange = chan_ff ? (2*PB+ptr_pkg::PRANGE_W)'(pedal1_range_ff)
                       : (2*PB+ptr_pkg::PRANGE_W)'(pedal0_range_ff);
      pmin = prange[PB-1:0];
      pmax = prange[2*PB-1:PB];
      pdiff_v = $signed({1'b0, pv_ff}) - $signed({1'b0, pmin});
      pspan_v = $signed({1'b0, pmax}) - $signed({1'b0, pmin});
      pedal_flat = (pmin == pmax);
      spd_c = CMPW'(spd_ff);
      band_end_c = CMPW'(regen_speed_band_ff[15:0]);
      band_full_c = CMPW'(regen_speed_band_ff[31:16]);
      min_rpm_c = CMPW'(ptr_pkg::REGEN_MIN_RPM);
      spd_end_c = spd_c - band_end_c;
      full_end_c = band_full_c - band_end_c;
      below_band = (spd_c < min_rpm_c) || (spd_c < band_end_c);
      out_band = below_band || (spd_c >= band_full_c);
      dz_zero = (dead_zone_ff >= 15'(ptr_pkg::FULL_PCT)) || (pn_ff < 16'(dead_zone_ff));
      level = (cw.lvl == ptr_pkg::LVL_BRAKE) ? regen_brake_level_ff : regen_pedal_limit_ff;
   end

   // Multiplier operand mux
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cw.mul)
         ptr_pkg::MUL_TAPER: begin
            mul_a = $signed({1'b0, spd_end_c[16:0]});
            mul_b = OPW'(level);
         end
         ptr_pkg::MUL_PEDAL: begin
            mul_a = ptr_pkg::FULL_PCT_OP;
            mul_b = OPW'(pdiff_v);
         end
         ptr_pkg::MUL_DZ: begin
            mul_a = $signed({2'b00, pn_ff}) - $signed({3'b000, dead_zone_ff});
            mul_b = ptr_pkg::FULL_PCT_OP;
         end
         ptr_pkg::MUL_FWD: begin
            mul_a = $signed({2'b00, pn_ff});
            mul_b = $signed({3'b000, throttle_ceiling_ff}) - OPW'(lim_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Divisor mux and operand magnitudes
   always_comb begin
      case (cw.div)
         ptr_pkg::DIV_TAPER: div_den = $signed({1'b0, full_end_c[16:0]});
         ptr_pkg::DIV_PEDAL: div_den = OPW'(pspan_v);
         ptr_pkg::DIV_DZ:    div_den = ptr_pkg::FULL_PCT_OP - $signed({3'b000, dead_zone_ff});
         ptr_pkg::DIV_PCT:   div_den = ptr_pkg::FULL_PCT_OP;
         default:            div_den = ptr_pkg::FULL_PCT_OP;
      endcase
      den_neg = -div_den;
      prod_neg = -prod_ff;
      den_mag = div_den[OPW-1] ? den_neg[DMAGW-1:0] : div_den[DMAGW-1:0];
      num_mag = prod_ff[NUMW-1] ? prod_neg[MAGW-1:0] : prod_ff[MAGW-1:0];
      div_q = div_neg_ff ? -$signed({1'b0, div_quo_ff}) : $signed({1'b0, div_quo_ff});
   end

   // Two restoring division steps per cycle
   always_comb begin
      dv_r = div_rem_ff;
      dv_q = div_quo_ff;
      for (int i = 0; i < 2; i++) begin
         dv_sh = {dv_r[16:0], dv_q[MAGW-1]};
         dv_t = {1'b0, dv_sh} - {2'b00, div_dmag_ff};
         dv_q = {dv_q[MAGW-2:0], ~dv_t[18]};
         dv_r = dv_t[18] ? dv_sh : dv_t[17:0];
      end
      div_rem_in = dv_r;
      div_quo_in = dv_q;
   end

   // Speed slew toward the new absolute speed
   always_comb begin
      speed_neg = -$signed({speed_ff[SB-1], speed_ff});
      spd_abs = speed_ff[SB-1] ? speed_neg[SB-1:0] : speed_ff;
      sl_slew = $signed({{(DIFW-15){1'b0}}, rpm_slew_ff});
      sl_diff = $signed(DIFW'(spd_abs)) - $signed(DIFW'(spd_ff));
      if (sl_diff > sl_slew) begin
         spd_in = spd_ff + SB'(rpm_slew_ff);
      end else if (sl_diff < -sl_slew) begin
         spd_in = spd_ff - SB'(rpm_slew_ff);
      end else begin
         spd_in = spd_abs;
      end
   end

   // Jump condition and next step
   always_comb begin
      case (cw.jmp)
         ptr_pkg::J_ALWAYS:     taken = 1'b1;
         ptr_pkg::J_NO_ITEM:    taken = !req_valid;
         ptr_pkg::J_NEUTRAL:    taken = (dir_ff == 2'sd0);
         ptr_pkg::J_BRAKE:      taken = brake_ff;
         ptr_pkg::J_OUT_BAND:   taken = out_band;
         ptr_pkg::J_PEDAL_FLAT: taken = pedal_flat;
         ptr_pkg::J_DZ_ZERO:    taken = dz_zero;
         ptr_pkg::J_NOT_FWD:    taken = (dir_ff != 2'sd1);
         ptr_pkg::J_DIV_BUSY:   taken = div_busy_ff;
         ptr_pkg::J_OUT_BUSY:   taken = out_busy;
         default:               taken = 1'b0;
      endcase
      if (taken) begin
         upc_in = cw.target;
      end else if (cw.ret) begin
         upc_in = ptr_pkg::U_IDLE;
      end else begin
         upc_in = upc_ff + 1'b1;
      end
   end

   // Write-back decode
   always_comb begin
      pn_in = pn_ff;
      lim_in = lim_ff;
      res_in = res_ff;
      unique case (cw.wb)
         ptr_pkg::WB_LIM_EDGE: lim_in = below_band ? 17'sd0 : 17'(level);
         ptr_pkg::WB_LIM_Q:    lim_in = div_q[16:0];
         ptr_pkg::WB_PN_ZERO:  pn_in = '0;
         ptr_pkg::WB_PN_CLAMP: begin
            if (div_q < 0) begin
               pn_in = '0;
            end else if (div_q > NUMW'(ptr_pkg::FULL_PCT)) begin
               pn_in = 16'(ptr_pkg::FULL_PCT);
            end else begin
               pn_in = div_q[15:0];
            end
         end
         ptr_pkg::WB_PN_Q:     pn_in = div_q[15:0];
         ptr_pkg::WB_RES_ZERO: res_in = '0;
         ptr_pkg::WB_RES_LIM:  res_in = 18'(lim_ff);
         ptr_pkg::WB_RES_PN:   res_in = $signed({2'b00, pn_ff});
         ptr_pkg::WB_RES_FWD:  res_in = 18'(lim_ff) + div_q[17:0];
         default: begin
            pn_in = pn_ff;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = out_busy;
      end
   end

   // Hold configuration; writes land at any time
   always_ff @(posedge clock) begin
      if (reset) begin
         pedal0_range_ff <= '0;
         pedal1_range_ff <= '0;
         regen_speed_band_ff <= '0;
         regen_pedal_limit_ff <= '0;
         regen_brake_level_ff <= '0;
         throttle_ceiling_ff <= ptr_pkg::THROTTLE_CEILING_RST;
         dead_zone_ff <= '0;
         rpm_slew_ff <= ptr_pkg::RPM_SLEW_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            ptr_pkg::CSR_PEDAL0_RANGE:      pedal0_range_ff <= csr_data[23:0];
            ptr_pkg::CSR_PEDAL1_RANGE:      pedal1_range_ff <= csr_data[23:0];
            ptr_pkg::CSR_REGEN_SPEED_BAND:  regen_speed_band_ff <= csr_data;
            ptr_pkg::CSR_REGEN_PEDAL_LIMIT: regen_pedal_limit_ff <= csr_data[15:0];
            ptr_pkg::CSR_REGEN_BRAKE_LEVEL: regen_brake_level_ff <= csr_data[15:0];
            ptr_pkg::CSR_THROTTLE_CEILING:  throttle_ceiling_ff <= csr_data[14:0];
            ptr_pkg::CSR_DEAD_ZONE:         dead_zone_ff <= csr_data[14:0];
            ptr_pkg::CSR_RPM_SLEW:          rpm_slew_ff <= csr_data[14:0];
            default:                        rpm_slew_ff <= rpm_slew_ff;
         endcase
      end
   end

   // Sequencer, state and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= ptr_pkg::U_IDLE;
         spd_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cw.wb == ptr_pkg::WB_SLEW) begin
            spd_ff <= spd_in;
         end
      end
   end

   // Latch the item, advance the datapath
   always_ff @(posedge clock) begin
      if (accept) begin
         pv_ff <= req_pedal_sample;
         chan_ff <= req_pedal_channel;
         brake_ff <= req_brake_pressed;
         speed_ff <= req_motor_speed;
         dir_ff <= req_drive_direction;
      end
      if (cw.mul != ptr_pkg::MUL_NONE) begin
         prod_ff <= mul_p[NUMW-1:0];
      end
      pn_ff <= pn_in;
      lim_ff <= lim_in;
      res_ff <= res_in;
      if (emit) begin
         rsp_data_ff <= res_ff[ptr_pkg::TORQUE_W-1:0];
      end
   end

   // Shared divider
   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else if (cw.div != ptr_pkg::DIV_NONE) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
         if (div_cnt_ff == '1) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cw.div != ptr_pkg::DIV_NONE) begin
         div_rem_ff <= '0;
         div_quo_ff <= num_mag;
         div_dmag_ff <= den_mag;
         div_neg_ff <= prod_ff[NUMW-1] ^ div_den[OPW-1];
      end else if (div_busy_ff) begin
         div_rem_ff <= div_rem_in;
         div_quo_ff <= div_quo_in;
      end
   end

`ifndef SYNTH
   // Divider runs only while the program sits in a wait step
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> (upc_ff == ptr_pkg::U_PED_WAIT || upc_ff == ptr_pkg::U_DZ_WAIT ||
                       upc_ff == ptr_pkg::U_FT_WAIT || upc_ff == ptr_pkg::U_FWD_WAIT ||
                       upc_ff == ptr_pkg::U_BT_WAIT))
      else $error("divider busy outside a wait step");

   // An accepted item starts with the speed slew
   a_accept_slew: assert property (@(posedge clock) disable iff (reset)
      accept |=> (upc_ff == ptr_pkg::U_SLEW))
      else $error("accepted item did not enter the slew step");

   // A new result appears only from the output step
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(upc_ff) == ptr_pkg::U_OUT))
      else $error("result raised outside the output step");

   // Filtered speed changes only in the slew step
   a_spd_slew: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && !$stable(spd_ff)) |-> ($past(upc_ff) == ptr_pkg::U_SLEW))
      else $error("filtered speed changed outside the slew step");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for pedal_to_torque_request_top: directed and random
// items, register settings between phases, item-by-item torque prediction.
// Depends on ptr_pkg and the pedal_to_torque_request_top RTL.
`timescale 1ns / 1ps

module testbench;
   import ptr_pkg::*;

   localparam int HALF_PERIOD = 10;
   localparam int RESET_CYCLES = 5;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_PER_PHASE = 275;
   localparam int NUM_PHASES = 6;
   localparam int HOLDOFF_EVERY = 400;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int MAX_PRINTED = 40;
   localparam longint RUN_LIMIT_NS = 15_000_000;

   typedef enum logic [1:0] {
      DIR_NEUTRAL = 2'b00,
      DIR_FORWARD = 2'b01,
      DIR_SPARE = 2'b10,
      DIR_REVERSE = 2'b11
   } drive_dir_e;

   typedef struct packed {
      logic [PEDAL_BITS-1:0] sample;
      logic channel;
      logic brake;
      logic [SPEED_BITS-1:0] speed;
      drive_dir_e direction;
   } pedal_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [PEDAL_BITS-1:0] req_pedal_sample = '0;
   logic req_pedal_channel = 1'b0;
   logic req_brake_pressed = 1'b0;
   logic signed [SPEED_BITS-1:0] req_motor_speed = '0;
   logic signed [1:0] req_drive_direction = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [TORQUE_W-1:0] rsp_torque_request;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Register copies, at reset values
   logic [PRANGE_W-1:0] pedal0_range = '0;
   logic [PRANGE_W-1:0] pedal1_range = '0;
   logic [31:0] regen_band = '0;
   logic signed [15:0] regen_pedal_lim = '0;
   logic signed [15:0] regen_brake_lvl = '0;
   logic [14:0] ceiling_pct = THROTTLE_CEILING_RST;
   logic [14:0] dead_zone_pct = '0;
   logic [14:0] slew_limit = RPM_SLEW_RST;
   logic [SPEED_BITS-1:0] filtered_rpm = '0;

   pedal_item_t pending_items[$];
   pedal_item_t in_flight;
   logic [TORQUE_W-1:0] torque_due[$];
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int items_accepted = 0;
   int holdoff_left = 0;
   logic holdoff_armed = 1'b1;
   int failures = 0;

   pedal_to_torque_request_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pedal_sample(req_pedal_sample),
      .req_pedal_channel(req_pedal_channel),
      .req_brake_pressed(req_brake_pressed),
      .req_motor_speed(req_motor_speed),
      .req_drive_direction(req_drive_direction),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_torque_request(rsp_torque_request),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Regen limit at the filtered speed: zero when slow, linear in the band
   function automatic longint regen_at_speed(input longint rpm, input longint level);
      longint end_rpm;
      longint full_rpm;
      end_rpm = regen_band[15:0];
      full_rpm = regen_band[31:16];
      if (rpm < REGEN_MIN_RPM || rpm < end_rpm) return 0;
      if (rpm < full_rpm) return (rpm - end_rpm) * level / (full_rpm - end_rpm);
      return level;
   endfunction

   // Pedal position in 1/256 percent, saturated to 0..100 %
   function automatic longint pedal_percent(input logic [PEDAL_BITS-1:0] sample,
                                            input logic channel);
      logic [PRANGE_W-1:0] rng;
      longint lo;
      longint hi;
      longint pos;
      longint pct;
      rng = channel ? pedal1_range : pedal0_range;
      lo = rng[PEDAL_BITS-1:0];
      hi = rng[2*PEDAL_BITS-1:PEDAL_BITS];
      pos = sample;
      if (lo == hi) return 0;
      pct = FULL_PCT * (pos - lo) / (hi - lo);
      if (pct < 0) pct = 0;
      if (pct > FULL_PCT) pct = FULL_PCT;
      return pct;
   endfunction

   // Advance the speed filter and work out the torque request of one item
   function automatic logic [TORQUE_W-1:0] torque_for_item(input pedal_item_t it);
      longint rpm;
      longint fil;
      longint slew;
      longint dz;
      longint pct;
      longint lim;
      longint top;
      longint res;
      rpm = $signed(it.speed);
      if (rpm < 0) rpm = -rpm;
      fil = filtered_rpm;
      slew = slew_limit;
      dz = dead_zone_pct;
      if (rpm - fil > slew) fil = fil + slew;
      else if (rpm - fil < -slew) fil = fil - slew;
      else fil = rpm;
      filtered_rpm = fil[SPEED_BITS-1:0];

      if (it.direction == DIR_NEUTRAL) begin
         res = 0;
      end else if (it.brake) begin
         res = regen_at_speed(fil, regen_brake_lvl);
      end else begin
         pct = pedal_percent(it.sample, it.channel);
         if (dz >= FULL_PCT || pct < dz) pct = 0;
         else pct = (pct - dz) * FULL_PCT / (FULL_PCT - dz);
         if (it.direction == DIR_FORWARD) begin
            lim = regen_at_speed(fil, regen_pedal_lim);
            top = ceiling_pct;
            res = lim + pct * (top - lim) / FULL_PCT;
         end else begin
            res = pct;
         end
      end
      return res[TORQUE_W-1:0];
   endfunction

   task automatic report_mismatch(input string msg);
      if (failures < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
      failures++;
   endtask

   task automatic queue_item(input int sample, input logic channel, input logic brake,
                             input int speed, input drive_dir_e direction);
      pedal_item_t it;
      it.sample = sample[PEDAL_BITS-1:0];
      it.channel = channel;
      it.brake = brake;
      it.speed = speed[SPEED_BITS-1:0];
      it.direction = direction;
      pending_items.push_back(it);
   endtask

   // Write one register and keep the local copy in step
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PEDAL0_RANGE: pedal0_range = data[PRANGE_W-1:0];
         CSR_PEDAL1_RANGE: pedal1_range = data[PRANGE_W-1:0];
         CSR_REGEN_SPEED_BAND: regen_band = data;
         CSR_REGEN_PEDAL_LIMIT: regen_pedal_lim = data[15:0];
         CSR_REGEN_BRAKE_LEVEL: regen_brake_lvl = data[15:0];
         CSR_THROTTLE_CEILING: ceiling_pct = data[14:0];
         CSR_DEAD_ZONE: dead_zone_pct = data[14:0];
         default: slew_limit = data[14:0];
      endcase
   endtask

   task automatic write_setting(input int p0_lo, input int p0_hi, input int p1_lo,
                                input int p1_hi, input int band_end, input int band_full,
                                input int pedal_lim, input int brake_lvl, input int ceil,
                                input int dz, input int slew);
      write_reg(CSR_PEDAL0_RANGE, (p0_hi << PEDAL_BITS) | p0_lo);
      write_reg(CSR_PEDAL1_RANGE, (p1_hi << PEDAL_BITS) | p1_lo);
      write_reg(CSR_REGEN_SPEED_BAND, (band_full << 16) | band_end);
      write_reg(CSR_REGEN_PEDAL_LIMIT, pedal_lim);
      write_reg(CSR_REGEN_BRAKE_LEVEL, brake_lvl);
      write_reg(CSR_THROTTLE_CEILING, ceil);
      write_reg(CSR_DEAD_ZONE, dz);
      write_reg(CSR_RPM_SLEW, slew);
   endtask

   // Wait until every item went in and every result came out, then settle
   task automatic wait_for_drain();
      do @(posedge clock);
      while (pending_items.size() != 0 || req_valid || torque_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: present queued items, hold them while stalled, predict on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            torque_due.push_back(torque_for_item(in_flight));
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               in_flight = pending_items.pop_front();
               req_valid <= 1'b1;
               req_pedal_sample <= in_flight.sample;
               req_pedal_channel <= in_flight.channel;
               req_brake_pressed <= in_flight.brake;
               req_motor_speed <= in_flight.speed;
               req_drive_direction <= in_flight.direction;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off at regular points of the item count
   always @(posedge clock) begin
      if (reset) begin
         holdoff_left <= 0;
         holdoff_armed <= 1'b1;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
      end else if (items_accepted % HOLDOFF_EVERY == HOLDOFF_EVERY / 2) begin
         if (holdoff_armed) begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_armed <= 1'b0;
         end
      end else begin
         holdoff_armed <= 1'b1;
      end
   end

   // Monitor: check each accepted result against the oldest prediction
   always @(posedge clock) begin
      logic [TORQUE_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (torque_due.size() == 0) begin
               report_mismatch($sformatf("unexpected torque request %0d",
                                         rsp_torque_request));
            end else begin
               want = torque_due.pop_front();
               if (rsp_torque_request !== want)
                  report_mismatch($sformatf("torque_request got %0d expected %0d",
                                            rsp_torque_request, $signed(want)));
            end
         end
         rsp_stall <= (holdoff_left != 0) || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Stimulus: defaults, directed items, then random phases under varied settings
   initial begin
      int walk_rpm;
      int pick;
      int speed;
      int sample;
      int band_end;
      drive_dir_e direction;
      walk_rpm = 1500;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct <= 14;
      recv_idle_pct <= 88;

      // Reset ranges are flat, so every pedal reads zero
      queue_item(2048, 1'b0, 1'b0, 500, DIR_FORWARD);
      queue_item(4095, 1'b1, 1'b0, -700, DIR_REVERSE);
      queue_item(0, 1'b0, 1'b1, 1000, DIR_FORWARD);
      wait_for_drain();

      // Directed: full slew so the speed lands where asked
      write_setting(400, 3600, 3800, 300, 500, 3000, -5120, -12800, 25600, 1280, 32767);
      queue_item(2000, 1'b0, 1'b0, 1000, DIR_NEUTRAL);
      queue_item(0, 1'b0, 1'b0, 0, DIR_FORWARD);
      queue_item(4095, 1'b0, 1'b0, 50, DIR_FORWARD);
      queue_item(400, 1'b0, 1'b0, 99, DIR_FORWARD);
      queue_item(3600, 1'b0, 1'b0, 1500, DIR_FORWARD);
      queue_item(500, 1'b0, 1'b0, 1500, DIR_FORWARD);
      queue_item(2000, 1'b1, 1'b0, 5000, DIR_FORWARD);
      queue_item(4095, 1'b1, 1'b0, 100, DIR_FORWARD);
      queue_item(0, 1'b1, 1'b0, 32767, DIR_FORWARD);
      queue_item(3000, 1'b0, 1'b0, -2000, DIR_REVERSE);
      queue_item(3000, 1'b1, 1'b0, -32768, DIR_SPARE);
      queue_item(1000, 1'b0, 1'b1, 50, DIR_FORWARD);
      queue_item(1000, 1'b0, 1'b1, 300, DIR_FORWARD);
      queue_item(1000, 1'b0, 1'b1, 500, DIR_FORWARD);
      queue_item(1000, 1'b1, 1'b1, -1750, DIR_REVERSE);
      queue_item(1000, 1'b0, 1'b1, 3000, DIR_FORWARD);
      queue_item(4095, 1'b0, 1'b1, 32767, DIR_SPARE);
      queue_item(4095, 1'b0, 1'b1, 2000, DIR_NEUTRAL);
      queue_item(700, 1'b0, 1'b0, 2500, DIR_FORWARD);
      queue_item(3599, 1'b1, 1'b0, -100, DIR_REVERSE);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_drain();
         // Sender idles lightly first, then the receiver, then neither
         if (phase == 2) begin
            send_idle_pct <= 88;
            recv_idle_pct <= 14;
         end else if (phase == 4) begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         case (phase)
            0: write_setting(400, 3600, 3800, 300, 500, 3000, -5120, -12800, 25600, 1280,
                             100);
            1: write_setting(0, 0, 0, 4095, 0, 65535, -25600, -25600, 0, 0, 0);
            2: write_setting(4095, 0, 2048, 2048, 65535, 0, 0, 0, 25600, 25344, 32767);
            default: begin
               band_end = $urandom_range(0, 3000);
               write_setting($urandom_range(0, 4095), $urandom_range(0, 4095),
                             $urandom_range(0, 4095), $urandom_range(0, 4095),
                             band_end, band_end + $urandom_range(0, 6000),
                             -$urandom_range(0, 25600), -$urandom_range(0, 25600),
                             $urandom_range(0, 25600),
                             (phase == 3) ? FULL_PCT :
                             (phase == 4) ? $urandom_range(0, 25344) : 32767,
                             $urandom_range(0, 1) ? $urandom_range(0, 300) :
                                                    $urandom_range(0, 32767));
            end
         endcase

         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            // Mostly a slow speed walk so the taper band gets crossed
            pick = $urandom_range(0, 600);
            walk_rpm = walk_rpm + pick - 300;
            if (walk_rpm > 12000) walk_rpm = 12000;
            if (walk_rpm < -12000) walk_rpm = -12000;
            pick = $urandom_range(0, 99);
            if (pick < 70) speed = walk_rpm;
            else if (pick < 85) speed = $urandom_range(0, 65535);
            else if (pick < 90) speed = -32768;
            else if (pick < 95) speed = 32767;
            else speed = $urandom_range(0, 1) ? 99 : 100;

            pick = $urandom_range(0, 99);
            if (pick < 40) direction = DIR_FORWARD;
            else if (pick < 65) direction = DIR_REVERSE;
            else if (pick < 85) direction = DIR_NEUTRAL;
            else direction = DIR_SPARE;

            pick = $urandom_range(0, 9);
            if (pick == 0) sample = 0;
            else if (pick == 1) sample = 4095;
            else sample = $urandom_range(0, 4095);

            queue_item(sample, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0),
                       speed, direction);
         end
      end

      wait_for_drain();
      if (torque_due.size() != 0)
         report_mismatch($sformatf("%0d torque requests never arrived", torque_due.size()));
      if (failures == 0) begin
         $display("PASS pedal_to_torque_request_top");
      end else begin
         $display("FAIL pedal_to_torque_request_top");
      end
      $finish;
   end

   // Drop the run if it hangs
   initial begin
      #(RUN_LIMIT_NS);
      $display("FAIL pedal_to_torque_request_top");
      $finish;
   end

endmodule
